>>> design/assert_macros.svh
// assertion macros shared by the design files
// no dependencies; clock clk and reset rst_n are taken from the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define AOS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked on every rising edge outside reset
`define AOS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/aos_pkg.sv
// types, constants and codes for the alert output sequencer
// no dependencies; used by every module of the block
package aos_pkg;

  localparam int PIN_COUNT       = 48;
  localparam int FLASH_PERIOD_MS = 1000;
  localparam int AUDIO_GRACE_MS  = 2000;

  localparam int PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int BUS_W = 48;
  localparam int REM_W = 26;
  localparam int EL_W  = 12;
  localparam int TOG_W = 10;

  localparam logic [REM_W-1:0] FAILSAFE_MS = REM_W'(600000);
  localparam logic [REM_W-1:0] MS_PER_SEC  = REM_W'(1000);
  localparam logic [EL_W-1:0]  ELAPSED_MAX = {EL_W{1'b1}};
  localparam logic [BUS_W-1:0] RESET_MASK  = 48'h8000_0008_c3f8;

  localparam logic FUNC_TRIGGER = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  localparam logic [1:0] MODE_CONT  = 2'd0;
  localparam logic [1:0] MODE_FLASH = 2'd1;
  localparam logic [1:0] MODE_PULSE = 2'd2;

  localparam logic [1:0] RULE_AUDIO    = 2'd0;
  localparam logic [1:0] RULE_CUSTOM   = 2'd1;
  localparam logic [1:0] RULE_FAILSAFE = 2'd2;

  typedef struct packed {
    logic        func;
    logic [5:0]  pin;
    logic [1:0]  mode;
    logic [1:0]  stop_rule;
    logic [15:0] duration_sec;
    logic        audio_on;
  } in_t;

  typedef struct packed {
    logic [BUS_W-1:0] pin_levels;
    logic [BUS_W-1:0] active_mask;
    logic             rejected;
  } out_t;

  // one channel's job record, carried from cell to cell
  typedef struct packed {
    logic             active;
    logic             level;
    logic [1:0]       mode;
    logic [1:0]       rule;
    logic [REM_W-1:0] rem;
    logic [EL_W-1:0]  elapsed;
    logic [TOG_W-1:0] since;
  } rec_t;

  // what the update unit applies to the record passing the head
  typedef struct packed {
    logic        tick;
    logic        start;
    logic [1:0]  mode;
    logic [1:0]  rule;
    logic [15:0] dur;
    logic        audio;
  } cmd_t;

endpackage

>>> design/aos_cell.sv
// one cell of the channel ring: holds a job record, passes it on when shifting
// depends on aos_pkg
module aos_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  aos_pkg::rec_t rec_in,
  output aos_pkg::rec_t rec_out
);
  import aos_pkg::*;

  rec_t rec_r;

  // only the job flag and the level need a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.active <= 1'b0;
      rec_r.level  <= 1'b0;
    end else if (shift_en) begin
      rec_r <= rec_in;
    end
  end

  assign rec_out = rec_r;

endmodule

>>> design/aos_step.sv
// update unit at the head of the ring: job start or one tick for one record
// depends on aos_pkg
module aos_step (
  input  aos_pkg::cmd_t cmd,
  input  aos_pkg::rec_t rec_in,
  output aos_pkg::rec_t rec_out
);
  import aos_pkg::*;

  logic [15:0]      dur_eff;
  logic [REM_W-1:0] start_rem;
  logic [REM_W-1:0] rem_dec;
  logic [EL_W-1:0]  el_inc;
  logic [TOG_W-1:0] since_inc;
  logic             off;

  always_comb begin
    // pulse length is at least one second
    if (cmd.mode == MODE_PULSE && cmd.dur == 16'd0) dur_eff = 16'd1;
    else                                            dur_eff = cmd.dur;

    if (cmd.mode == MODE_PULSE || cmd.rule == RULE_CUSTOM)
      start_rem = REM_W'(REM_W'(dur_eff) * MS_PER_SEC);
    else
      start_rem = FAILSAFE_MS;

    rem_dec   = (rec_in.rem != '0) ? rec_in.rem - 1'b1 : '0;
    el_inc    = (rec_in.elapsed != ELAPSED_MAX) ? rec_in.elapsed + 1'b1 : rec_in.elapsed;
    since_inc = rec_in.since + 1'b1;

    off = (rem_dec == '0) ||
          (rec_in.rule == RULE_AUDIO && el_inc > EL_W'(AUDIO_GRACE_MS) && !cmd.audio);

    rec_out = rec_in;
    if (cmd.start) begin
      rec_out.active  = 1'b1;
      rec_out.level   = 1'b1;
      rec_out.mode    = cmd.mode;
      rec_out.rule    = cmd.rule;
      rec_out.rem     = start_rem;
      rec_out.elapsed = '0;
      rec_out.since   = '0;
    end else if (cmd.tick && rec_in.active) begin
      rec_out.rem     = rem_dec;
      rec_out.elapsed = el_inc;
      rec_out.since   = since_inc;
      if (off) begin
        rec_out.active = 1'b0;
        rec_out.level  = 1'b0;
      end else if (rec_in.mode == MODE_FLASH && since_inc >= TOG_W'(FLASH_PERIOD_MS)) begin
        rec_out.level = !rec_in.level;
        rec_out.since = '0;
      end
    end
  end

endmodule

>>> design/alert_output_sequencer_unit.sv
// top level of the alert output sequencer: ring of channel cells, head update
// unit, item control and output register
// depends on aos_pkg, aos_cell, aos_step and assert_macros.svh
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one beat per item: a
//   trigger for one pin or a one-millisecond tick. Output channel
//   out_valid/out_ready/out_data returns one beat per item with every pin's
//   level, the running-job mask and the reject flag.
//   cfg_wr_en/cfg_wr_data write the valid-pin mask mask_r, taken on the edge it is high.
//   Each item rotates the whole ring of PIN_COUNT cells once through the
//   single update unit, one channel per cycle, then loads the output register
//   when that register is free or being read. One item is in work at a time;
//   the next beat is taken once the result sits in the output register.
//   If the receiver stalls, the result waits in the output register and one
//   more item may be accepted and run; it then holds until the register frees.
//   Reset clears all jobs and pin levels and loads the default pin mask.
module alert_output_sequencer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aos_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aos_pkg::out_t      out_data,
  input  logic               cfg_wr_en,
  input  logic [47:0]        cfg_wr_data
);
  import aos_pkg::*;

  `include "assert_macros.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [PIN_W-1:0]     cnt_r, cnt_nxt;
  logic [PIN_COUNT-1:0] mask_r;
  in_t                  item_r;
  logic                 start_ok_r;
  logic                 rej_r;
  logic                 out_valid_r;
  out_t                 out_r;

  logic                 in_fire;
  logic                 pin_ok;
  logic                 shift_en;
  logic                 emit_go;
  cmd_t                 cmd;
  rec_t                 rec_q [PIN_COUNT];
  rec_t                 head_nxt;
  logic [PIN_COUNT-1:0] levels;
  logic [PIN_COUNT-1:0] actives;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign shift_en  = (state_r == ST_RUN);
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pin_ok = ({1'b0, in_data.pin} < 7'(PIN_COUNT)) && mask_r[in_data.pin[PIN_W-1:0]];

  // record of channel cnt_r sits in cell 0 during the run
  always_comb begin
    cmd.tick  = (item_r.func == FUNC_TICK);
    cmd.start = start_ok_r && (6'(cnt_r) == item_r.pin);
    cmd.mode  = item_r.mode;
    cmd.rule  = item_r.stop_rule;
    cmd.dur   = item_r.duration_sec;
    cmd.audio = item_r.audio_on;
  end

  aos_step u_step (
    .cmd     (cmd),
    .rec_in  (rec_q[0]),
    .rec_out (head_nxt)
  );

  for (genvar i = 0; i < PIN_COUNT; i++) begin : g_cell
    if (i == PIN_COUNT - 1) begin : g_tail
      aos_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .rec_in   (head_nxt),
        .rec_out  (rec_q[i])
      );
    end else begin : g_body
      aos_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .rec_in   (rec_q[i+1]),
        .rec_out  (rec_q[i])
      );
    end
  end

  // after a full turn every record is back in its home cell
  always_comb begin
    for (int i = 0; i < PIN_COUNT; i++) begin
      levels[i]  = rec_q[i].level;
      actives[i] = rec_q[i].active;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (cnt_r == PIN_W'(PIN_COUNT - 1)) begin
          state_nxt = ST_EMIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      mask_r      <= PIN_COUNT'(RESET_MASK);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) mask_r <= PIN_COUNT'(cfg_wr_data);
      if (emit_go)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r     <= in_data;
      start_ok_r <= (in_data.func == FUNC_TRIGGER) && pin_ok;
      rej_r      <= (in_data.func == FUNC_TRIGGER) && !pin_ok;
    end
    if (emit_go) begin
      out_r.pin_levels  <= BUS_W'(levels);
      out_r.active_mask <= BUS_W'(actives);
      out_r.rejected    <= rej_r;
    end
  end

  `AOS_ASSERT_NXT(a_run_ends, (state_r == ST_RUN && cnt_r == PIN_W'(PIN_COUNT - 1)),
                  (state_r == ST_EMIT), "ring turn did not end in emit")
  `AOS_ASSERT_IMP(a_load_from_emit, $rose(out_valid_r), ($past(state_r) == ST_EMIT),
                  "output beat raised outside emit")
  `AOS_ASSERT_IMP(a_level_needs_job, out_valid_r,
                  ((out_r.pin_levels & ~out_r.active_mask) == '0),
                  "pin driven high without a running job")

endmodule
